// File: hdl/plst_pkg.sv
package plst_pkg;

  // Command codes carried by the command field.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // What every cell of the chain does this cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  localparam int unsigned WordW = 32;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [WordW-1:0]  value;
  } cell_ctrl_t;

endpackage

// File: hdl/plst_cell.sv
module plst_cell #(
  parameter int unsigned PosW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                              clk_i,
  input  plst_pkg::cell_ctrl_t              ctrl_i,
  input  logic [PosW-1:0]                   pos_i,
  input  logic signed [plst_pkg::WordW-1:0] left_i,   // entry of cell Idx-1
  input  logic signed [plst_pkg::WordW-1:0] right_i,  // entry of cell Idx+1
  output logic signed [plst_pkg::WordW-1:0] entry_o,
  output logic                              hit_o
);
  import plst_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic signed [WordW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = left_i;
        end else if (MyIdx == pos_i) begin
          entry_d = ctrl_i.value;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = (entry_q == ctrl_i.value);

endmodule

// File: hdl/positional_list_engine.sv
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// words held in a chain of cells, one word per cell. Every command gives
// exactly one result item (status, found position, length after the command).
// For insert and remove, each cell loads from its left neighbor, its right
// neighbor, the command value, or holds, all in the same edge, and the
// result is registered at that edge. For find, all cells compare against
// the value at acceptance and the match bits are captured, then a scan
// walks that match vector one cell per cycle while the output register is
// free, ending at the first match or at the entry count when nothing matches.
// A new item is taken when the block is not scanning and the output register
// is free or being emptied in the same cycle. The reported found position
// and length are the low 4 and 5 bits of the internal values.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [4:0]                        position_i,
  input  logic signed [plst_pkg::WordW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [3:0]                        found_position_o,
  output logic [4:0]                        length_o
);
  import plst_pkg::*;

  // Count width holds 0..CAPACITY; the compare width also fits the
  // 5-bit position field.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [CAPACITY-1:0] hit_q;
  logic [CntW-1:0]     scan_q;
  logic                out_valid_q;
  status_e             status_q;
  logic [3:0]          found_q;
  logic [4:0]          length_q;

  logic                accept;
  logic                out_free;
  logic                out_load;
  status_e             status_d;
  cell_op_e            op_d;
  cell_ctrl_t          ctrl;
  logic [PosW-1:0]     pos_ext;
  logic [PosW-1:0]     cnt_ext;
  logic [PosW-1:0]     cnt_d_ext;
  logic [PosW-1:0]     scan_ext;

  logic signed [WordW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;
  logic [CAPACITY-1:0]     hit_live;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // A result is loaded at once for insert, remove and unused codes, and
  // when the find scan ends.
  assign out_load = (accept && (command_i != CMD_FIND)) ||
                    ((state_q == S_SCAN) && out_free &&
                     ((scan_q == count_q) || hit_q[0]));

  assign pos_ext   = PosW'(position_i);
  assign cnt_ext   = PosW'(count_q);
  assign cnt_d_ext = PosW'(count_d);
  assign scan_ext  = PosW'(scan_q);

  // Command checks; cells move only for a command that succeeds.
  always_comb begin
    status_d = ST_OK;
    op_d     = OP_HOLD;
    count_d  = count_q;
    unique case (command_i)
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_BAD_POS;
        end else if (count_q == CapCnt) begin
          status_d = ST_FULL;
        end else begin
          op_d    = OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_BAD_POS;
        end else begin
          op_d    = OP_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
      CMD_FIND: status_d = ST_OK;
      default:  status_d = ST_BAD_POS;  // unused code: rejected, list kept
    endcase
  end

  assign ctrl.op    = accept ? op_d : OP_HOLD;
  assign ctrl.value = value_i;

  // The chain. End cells take the command value from the missing side;
  // what lands beyond the entry count is never read.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = value_i;
    end else begin : g_left
      assign left_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = value_i;
    end else begin : g_right
      assign right_w = entry[i+1];
    end

    plst_cell #(
      .PosW (PosW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[i]),
      .hit_o   (cell_hit[i])
    );

    // only entries below the count may match
    assign hit_live[i] = cell_hit[i] && (PosW'(i) < cnt_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hit_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= '0;
      length_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (command_i == CMD_FIND) begin
              hit_q   <= hit_live;
              scan_q  <= '0;
              state_q <= S_SCAN;
            end else begin
              status_q    <= status_d;
              found_q     <= '0;
              length_q    <= cnt_d_ext[4:0];
            end
          end
        end
        S_SCAN: begin
          // wait here while the previous result is still held
          if (out_free) begin
            if (scan_q == count_q) begin
              status_q    <= ST_NOT_FOUND;
              found_q     <= '0;
              length_q    <= cnt_ext[4:0];
              state_q     <= S_IDLE;
            end else if (hit_q[0]) begin
              status_q    <= ST_OK;
              found_q     <= scan_ext[3:0];
              length_q    <= cnt_ext[4:0];
              state_q     <= S_IDLE;
            end else begin
              hit_q  <= hit_q >> 1;
              scan_q <= scan_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign length_o         = length_q;

endmodule

// File: tb/tb_positional_list_engine.sv
`timescale 1ns / 100ps

module tb_positional_list_engine;
  import plst_pkg::*;

  localparam int unsigned ListDepth = 16;
  localparam int unsigned LongHold  = 300;   // receiver hold-off, cycles
  localparam int unsigned StallLimit = 2000; // cycles with no handshake at all
  localparam int unsigned TailWait  = 40;

  // Command code 3 is not decoded; the block answers it with bad position.
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct {
    status_e    status;
    logic [3:0] found_position;
    logic [4:0] length;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CMD_FIND;
  logic [4:0]  position_i = '0;
  logic signed [WordW-1:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  found_position_o;
  logic [4:0]  length_o;

  // Shadow of the list contents, updated at every accepted item.
  logic signed [WordW-1:0] list_words [ListDepth];
  int unsigned             list_len = 0;
  list_result_t            pending_results [$];

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  logic        long_hold_req = 1'b0;

  positional_list_engine #(
    .CAPACITY(ListDepth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .length_o         (length_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List predictor: applies one command to the shadow list and returns the
  // answer the block must give for it.
  // ---------------------------------------------------------------------------
  function automatic list_result_t apply_command(input logic [1:0] cmd,
                                                 input logic [4:0] pos,
                                                 input logic signed [WordW-1:0] val);
    list_result_t r;
    int unsigned  idx;
    r.status = ST_OK;
    r.found_position = '0;
    case (cmd)
      CMD_INSERT: begin
        // Position check wins over the full check.
        if (pos > list_len) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= ListDepth) begin
          r.status = ST_FULL;
        end else begin
          for (idx = list_len; idx > pos; idx--) list_words[idx] = list_words[idx - 1];
          list_words[pos] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (idx = pos; idx + 1 < list_len; idx++) list_words[idx] = list_words[idx + 1];
          list_len--;
        end
      end
      CMD_FIND: begin
        // First match only; an empty list simply finds nothing.
        r.status = ST_NOT_FOUND;
        for (idx = 0; idx < list_len; idx++) begin
          if (r.status == ST_NOT_FOUND && list_words[idx] == val) begin
            r.status = ST_OK;
            r.found_position = idx[3:0];
          end
        end
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.length = list_len[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Results are checked before the item of the same edge is predicted, so a
  // result can never be matched against an item accepted in the same cycle.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item pending", status_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (found_position_o != want.found_position) begin
            report_mismatch("found_position", found_position_o, want.found_position);
          end
          if (length_o != want.length) report_mismatch("length", length_o, want.length);
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(apply_command(command_i, position_i, value_i));
      end
    end
  end

  // Watchdog: a run of cycles with no handshake on either side means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("positional_list_engine test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : sink_ctrl
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high afterwards so back-to-back items go out without a bubble.
  task automatic send_item(input logic [1:0] cmd, input logic [4:0] pos,
                           input logic signed [WordW-1:0] val);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender goes quiet until every result has come back.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Mix of fully random words, a small pool that makes duplicates likely,
  // the two extremes, and words already held in the list.
  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6, 7:       return $signed($urandom_range(0, 8)) - 4;
      8:             return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:       return (list_len == 0) ? $urandom() :
                            list_words[$urandom_range(0, list_len - 1)];
    endcase
  endfunction

  // Empty-list answers, bad positions, the unused code, extreme words,
  // duplicates (first match wins) and removal at head, middle and tail.
  task automatic test_special_cases();
    send_item(CMD_FIND,   5'd0,  32'sd0);
    send_item(CMD_REMOVE, 5'd0,  32'sd0);
    send_item(CMD_REMOVE, 5'd31, -32'sd1);      // empty wins over bad position
    send_item(CMD_INSERT, 5'd1,  32'sd7);       // past the end of an empty list
    send_item(CmdUnused,  5'd0,  32'sd5);
    send_item(CMD_INSERT, 5'd0,  32'sh7fff_ffff);
    send_item(CMD_INSERT, 5'd1,  32'sh8000_0000);
    send_item(CMD_INSERT, 5'd1,  -32'sd1);
    send_item(CMD_INSERT, 5'd0,  32'sd0);
    send_item(CMD_INSERT, 5'd4,  -32'sd1);      // append a duplicate
    send_item(CMD_FIND,   5'd31, -32'sd1);
    send_item(CMD_FIND,   5'd0,  32'sh8000_0000);
    send_item(CMD_FIND,   5'd0,  32'sd0);
    send_item(CMD_FIND,   5'd0,  32'sd12345);
    send_item(CMD_REMOVE, 5'd5,  32'sd0);       // position equal to length
    send_item(CMD_REMOVE, 5'd4,  32'sd0);
    send_item(CMD_REMOVE, 5'd0,  32'sh7fff_ffff);
    send_item(CMD_REMOVE, 5'd1,  32'sd0);
    send_item(CMD_INSERT, 5'd3,  32'sd9);
    send_item(CmdUnused,  5'd31, -32'sd1);
    send_item(CMD_REMOVE, 5'd1,  32'sd0);
    send_item(CMD_REMOVE, 5'd0,  32'sd0);
    send_item(CMD_FIND,   5'd16, 32'sh7fff_ffff);
    wait_results_done();
  endtask

  // Fill to capacity, probe the full list, then empty it again.
  task automatic test_full_list();
    int unsigned held;
    for (held = 0; held < ListDepth; held++) begin
      send_item(CMD_INSERT, 5'($urandom_range(0, held)), pick_word());
    end
    send_item(CMD_INSERT, 5'd0,  32'sd1);       // full
    send_item(CMD_INSERT, 5'd16, 32'sd1);       // full, position still legal
    send_item(CMD_INSERT, 5'd17, 32'sd1);       // bad position checked first
    send_item(CMD_INSERT, 5'd31, 32'sd1);
    send_item(CMD_REMOVE, 5'd16, 32'sd0);
    send_item(CMD_FIND,   5'd0,  pick_word());
    for (held = ListDepth; held > 0; held--) begin
      send_item(CMD_REMOVE, 5'($urandom_range(0, held - 1)), 32'sd0);
    end
    send_item(CMD_REMOVE, 5'd0,  32'sd0);
    wait_results_done();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    long_hold_req <= 1'b1;
    repeat (40) send_item(CMD_INSERT, 5'($urandom_range(0, 16)), pick_word());
    wait_results_done();
  endtask

  // Mostly well-formed commands with random content; the mix leans toward
  // remove as the list fills so its length sweeps between empty and full.
  task automatic test_random_traffic(input int unsigned chunks, input bit allow_idle);
    int unsigned chunk;
    int unsigned n;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [4:0]  pos;
    for (chunk = 0; chunk < chunks; chunk++) begin
      sender_gaps = allow_idle && ($urandom_range(0, 2) != 0);
      sink_stalls = allow_idle && ($urandom_range(0, 2) != 0);
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        pos  = 5'($urandom_range(0, 31));
        if (pick < 5) begin
          cmd = CmdUnused;                       // noise: unused code
        end else if (pick < 10) begin
          cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE;  // noise: any position
        end else if (pick < 35) begin
          cmd = CMD_FIND;
        end else if (list_len == 0 ||
                     (list_len < ListDepth && $urandom_range(0, ListDepth) >= list_len)) begin
          cmd = CMD_INSERT;
          pos = 5'($urandom_range(0, list_len));
        end else begin
          cmd = CMD_REMOVE;
          pos = 5'($urandom_range(0, list_len - 1));
        end
        send_item(cmd, pos, pick_word());
      end
      if ($urandom_range(0, 1) == 0) wait_results_done();
    end
  endtask

  initial begin : main
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_special_cases();
    test_full_list();
    test_output_backpressure();
    test_random_traffic(13, 1'b1);
    // Last stretch runs at full rate on both sides.
    test_random_traffic(2, 1'b0);

    wait_results_done();
    repeat (TailWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/plst_pkg.sv
hdl/plst_cell.sv
hdl/positional_list_engine.sv
tb/tb_positional_list_engine.sv
